FILE: src/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types, constants and tables of the go-to-goal controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int SQRT_STEPS          = 25;
    localparam int DEF_CORDIC_STAGES   = 18;
    localparam int MAX_CORDIC_STAGES   = 32;

    localparam logic signed [33:0] PI_Q30     = 34'sd3373259426;
    localparam logic signed [35:0] PI_Q30_W   = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;

    localparam logic [29:0] ATAN_Q30 [MAX_CORDIC_STAGES] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef enum logic [0:0] {
        REG_GAIN         = 1'b0,
        REG_CATCH_RADIUS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic               valid;
        logic               caught;
        logic signed [18:0] hd;
        logic [49:0]        n;
        logic [27:0]        rem;
        logic [24:0]        root;
        logic signed [27:0] x;
        logic signed [27:0] y;
        logic signed [33:0] z;
    } iter_t;

endpackage

FILE: src/gtg_front.sv
// ----------------------------------------------------------------------------
// gtg_front
// Offsets, squares, catch test and CORDIC seeding, three register stages.
// ----------------------------------------------------------------------------
module gtg_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [23:0]  own_x,
    input  logic signed [23:0]  own_y,
    input  logic signed [18:0]  own_heading,
    input  logic signed [23:0]  target_x,
    input  logic signed [23:0]  target_y,
    input  logic [22:0]         catch_radius,
    output gtg_pkg::iter_t      q
);
    import gtg_pkg::*;

    logic               v1_reg, v2_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic signed [18:0] hd1_reg, hd2_reg;
    logic [48:0]        px_reg, py_reg;
    logic signed [27:0] x0_reg, y0_reg;
    logic signed [33:0] z0_reg;
    logic [45:0]        r2_reg;
    iter_t              q_reg, q_next;

    logic signed [49:0] pxw, pyw;
    logic signed [27:0] dx28, dy28;
    logic [49:0]        sum;

    assign pxw  = dx_reg * dx_reg;
    assign pyw  = dy_reg * dy_reg;
    assign dx28 = {{3{dx_reg[24]}}, dx_reg};
    assign dy28 = {{3{dy_reg[24]}}, dy_reg};
    assign sum  = {1'b0, px_reg} + {1'b0, py_reg};

    always_comb begin
        q_next        = '0;
        q_next.valid  = v2_reg;
        q_next.caught = (sum <= {4'b0, r2_reg});
        q_next.hd     = hd2_reg;
        q_next.n      = sum;
        q_next.x      = x0_reg;
        q_next.y      = y0_reg;
        q_next.z      = z0_reg;
    end

    always_ff @(posedge aclk) begin
        r2_reg <= catch_radius * catch_radius;
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            q_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg  <= in_valid;
            dx_reg  <= {target_x[23], target_x} - {own_x[23], own_x};
            dy_reg  <= {target_y[23], target_y} - {own_y[23], own_y};
            hd1_reg <= own_heading;
            v2_reg  <= v1_reg;
            hd2_reg <= hd1_reg;
            px_reg  <= pxw[48:0];
            py_reg  <= pyw[48:0];
            if (dx_reg[24]) begin
                x0_reg <= -dx28;
                y0_reg <= -dy28;
                z0_reg <= dy_reg[24] ? -PI_Q30 : PI_Q30;
            end else begin
                x0_reg <= dx28;
                y0_reg <= dy28;
                z0_reg <= '0;
            end
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: src/gtg_iter_stage.sv
// ----------------------------------------------------------------------------
// gtg_iter_stage
// One square-root digit step and/or one CORDIC vectoring step, registered.
// ----------------------------------------------------------------------------
module gtg_iter_stage #(
    parameter int IDX       = 0,
    parameter bit DO_SQRT   = 1'b1,
    parameter bit DO_CORDIC = 1'b1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  gtg_pkg::iter_t d,
    output gtg_pkg::iter_t q
);
    import gtg_pkg::*;

    localparam int AIDX = IDX % MAX_CORDIC_STAGES;

    iter_t              q_reg, q_next;
    logic [27:0]        rem_s, trial;
    logic signed [27:0] xs, ys;
    logic signed [33:0] at;

    assign rem_s = {d.rem[25:0], d.n[49:48]};
    assign trial = {1'b0, d.root, 2'b01};
    assign xs    = d.x >>> AIDX;
    assign ys    = d.y >>> AIDX;
    assign at    = {4'b0, ATAN_Q30[AIDX]};

    always_comb begin
        q_next = d;
        if (DO_SQRT) begin
            q_next.n = {d.n[47:0], 2'b00};
            if (rem_s >= trial) begin
                q_next.rem  = rem_s - trial;
                q_next.root = {d.root[23:0], 1'b1};
            end else begin
                q_next.rem  = rem_s;
                q_next.root = {d.root[23:0], 1'b0};
            end
        end
        if (DO_CORDIC) begin
            if (!d.y[27]) begin
                q_next.x = d.x + ys;
                q_next.y = d.y - xs;
                q_next.z = d.z + at;
            end else begin
                q_next.x = d.x - ys;
                q_next.y = d.y + xs;
                q_next.z = d.z - at;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: src/gtg_back.sv
// ----------------------------------------------------------------------------
// gtg_back
// Heading error wrap, gain products and output saturation, three stages.
// ----------------------------------------------------------------------------
module gtg_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  gtg_pkg::iter_t d,
    input  logic [23:0]    gain,
    output logic           out_valid,
    output logic [30:0]    linear_velocity,
    output logic [31:0]    angular_velocity,
    output logic           caught
);
    import gtg_pkg::*;

    logic               v1_reg, v2_reg, out_valid_reg;
    logic               c1_reg, c2_reg, caught_reg;
    logic signed [35:0] err_reg;
    logic [24:0]        dist_reg;
    logic [48:0]        lin_p_reg;
    logic [41:0]        lo_reg;
    logic signed [42:0] hi_reg;
    logic [30:0]        lin_reg;
    logic [31:0]        ang_reg;

    logic signed [35:0] err0;
    logic signed [35:0] err_next;
    logic signed [42:0] hi_next;
    logic signed [61:0] full;
    logic signed [61:0] sh;
    logic [31:0]        lin_sh;

    assign err0 = {{2{d.z[33]}}, d.z} - {{3{d.hd[18]}}, d.hd, 14'b0};

    always_comb begin
        if (err0 > PI_Q30_W) begin
            err_next = err0 - TWO_PI_Q30;
        end else if (err0 < -PI_Q30_W) begin
            err_next = err0 + TWO_PI_Q30;
        end else begin
            err_next = err0;
        end
    end

    assign hi_next = $signed({1'b0, gain}) * $signed(err_reg[35:18]);
    assign full    = ({{19{hi_reg[42]}}, hi_reg} <<< 18) + {20'b0, lo_reg};
    assign sh      = full >>> 30;
    assign lin_sh  = lin_p_reg[48:17];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= d.valid;
            c1_reg    <= d.caught;
            err_reg   <= err_next;
            dist_reg  <= d.root;
            v2_reg    <= v1_reg;
            c2_reg    <= c1_reg;
            lin_p_reg <= gain * dist_reg;
            lo_reg    <= gain * err_reg[17:0];
            hi_reg    <= hi_next;
            out_valid_reg <= v2_reg;
            caught_reg    <= c2_reg;
            if (c2_reg) begin
                lin_reg <= '0;
                ang_reg <= '0;
            end else begin
                lin_reg <= lin_sh[31] ? 31'h7FFF_FFFF : lin_sh[30:0];
                if (sh > 62'sd2147483647) begin
                    ang_reg <= 32'h7FFF_FFFF;
                end else if (sh < -62'sd2147483648) begin
                    ang_reg <= 32'h8000_0000;
                end else begin
                    ang_reg <= sh[31:0];
                end
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign linear_velocity  = lin_reg;
    assign angular_velocity = ang_reg;
    assign caught           = caught_reg;

endmodule

FILE: src/go_to_goal_p_controller.sv
// ----------------------------------------------------------------------------
// go_to_goal_p_controller
// Proportional go-to-goal controller with pipelined square root and CORDIC.
// ----------------------------------------------------------------------------
// The block accepts one pose beat in every cycle unless the output stalls, and
// returns its speed command through the front stages, then the square-root and
// CORDIC pipeline with at most one digit and one rotation per stage, then the
// back stages. Beats whose pose or target flag is clear produce no result. A
// stall on the output holds the whole pipeline without loss.
module go_to_goal_p_controller #(
    parameter int CORDIC_STAGES = gtg_pkg::DEF_CORDIC_STAGES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_index,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // own_x, own_y, own_heading, target_x, target_y, zero pad
    input  logic [119:0] s_tdata,
    // pose_valid, target_valid
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // linear_velocity, angular_velocity, zero pad
    output logic [63:0]  m_tdata,
    // caught
    output logic [0:0]   m_tuser
);
    import gtg_pkg::*;

    localparam int CS_EFF = (CORDIC_STAGES > MAX_CORDIC_STAGES) ?
                            MAX_CORDIC_STAGES : CORDIC_STAGES;
    localparam int NSTG   = (CS_EFF > SQRT_STEPS) ? CS_EFF : SQRT_STEPS;

    logic [23:0] gain_reg;
    logic [22:0] radius_reg;
    logic        en;
    logic [30:0] lin;
    logic [31:0] ang;
    logic        caught;
    iter_t       chain [NSTG+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= 24'd65536;
            radius_reg <= 23'd32768;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN:         gain_reg   <= cfg_wdata;
                REG_CATCH_RADIUS: radius_reg <= cfg_wdata[22:0];
                default: ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    gtg_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid && s_tuser[0] && s_tuser[1]),
        .own_x        (s_tdata[23:0]),
        .own_y        (s_tdata[47:24]),
        .own_heading  (s_tdata[66:48]),
        .target_x     (s_tdata[90:67]),
        .target_y     (s_tdata[114:91]),
        .catch_radius (radius_reg),
        .q            (chain[0])
    );

    for (genvar i = 0; i < NSTG; i++) begin : g_iter
        gtg_iter_stage #(
            .IDX       (i),
            .DO_SQRT   (i < SQRT_STEPS),
            .DO_CORDIC (i < CS_EFF)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d       (chain[i]),
            .q       (chain[i+1])
        );
    end

    gtg_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .d                (chain[NSTG]),
        .gain             (gain_reg),
        .out_valid        (m_tvalid),
        .linear_velocity  (lin),
        .angular_velocity (ang),
        .caught           (caught)
    );

    assign m_tdata = {1'b0, ang, lin};
    assign m_tuser = caught;

endmodule

FILE: dv/gtg_checker.sv
// ----------------------------------------------------------------------------
// gtg_checker
// Watches the pose and command streams of the go-to-goal controller, predicts
// each speed command from the accepted pose beats and compares field by field.
// ----------------------------------------------------------------------------
module gtg_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_index,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gtg_pkg::*;

    typedef struct packed {
        logic [30:0]        lin;
        logic signed [31:0] ang;
        logic               caught;
    } command_t;

    localparam longint PI_L = 64'sd3373259426;
    localparam longint TWO_PI_L = 64'sd6746518852;
    localparam int FIFO_DEPTH = 256;

    logic [23:0] gain_q;
    logic [22:0] radius_q;
    command_t    cmd_fifo [FIFO_DEPTH];
    int          wr_count;
    int          rd_count;

    assign pending = wr_count - rd_count;

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) begin
            return v >>> s;
        end
        return -((((-v) - 1) >>> s) + 1);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root, bit_v;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= root + bit_v) begin
                n -= root + bit_v;
                root = (root >> 1) + bit_v;
            end else begin
                root >>= 1;
            end
            bit_v >>= 2;
        end
        return root;
    endfunction

    function automatic longint bearing_q30(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_L : -PI_L;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < DEF_CORDIC_STAGES && i < MAX_CORDIC_STAGES; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += longint'(ATAN_Q30[i]);
            end else begin
                x -= ys;
                y += xs;
                z -= longint'(ATAN_Q30[i]);
            end
        end
        return z;
    endfunction

    function automatic command_t steer_command(logic [119:0] d);
        command_t c;
        longint ox, oy, hd, tx, ty, dx, dy, err, ang;
        longint unsigned sum, r2, lin;
        ox = longint'($signed(d[23:0]));
        oy = longint'($signed(d[47:24]));
        hd = longint'($signed(d[66:48]));
        tx = longint'($signed(d[90:67]));
        ty = longint'($signed(d[114:91]));
        dx = tx - ox;
        dy = ty - oy;
        sum = dx * dx + dy * dy;
        r2 = longint'(radius_q) * longint'(radius_q);
        c = '0;
        if (sum <= r2) begin
            c.caught = 1'b1;
            return c;
        end
        lin = (longint'(gain_q) * int_sqrt(sum)) >> 17;
        if (lin > 64'h7FFFFFFF) lin = 64'h7FFFFFFF;
        err = bearing_q30(dy, dx) - hd * 16384;
        if (err > PI_L) begin
            err -= TWO_PI_L;
        end else if (err < -PI_L) begin
            err += TWO_PI_L;
        end
        ang = floor_shift(longint'(gain_q) * err, 30);
        if (ang > 64'sd2147483647) begin
            ang = 64'sd2147483647;
        end else if (ang < -64'sd2147483648) begin
            ang = -64'sd2147483648;
        end
        c.lin = lin[30:0];
        c.ang = ang[31:0];
        return c;
    endfunction

    always @(posedge aclk) begin
        command_t want, got;
        if (!aresetn) begin
            gain_q <= 24'd65536;
            radius_q <= 23'd32768;
            wr_count <= 0;
            rd_count <= 0;
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_GAIN) begin
                    gain_q <= cfg_wdata;
                end else begin
                    radius_q <= cfg_wdata[22:0];
                end
            end
            if (s_tvalid && s_tready && s_tuser[0] && s_tuser[1]) begin
                cmd_fifo[wr_count[7:0]] <= steer_command(s_tdata);
                wr_count <= wr_count + 1;
            end
            if (m_tvalid && m_tready) begin
                got.lin = m_tdata[30:0];
                got.ang = m_tdata[62:31];
                got.caught = m_tuser[0];
                if (wr_count == rd_count) begin
                    $display("%0t: unexpected beat lin=%h ang=%h caught=%b", $time,
                             got.lin, got.ang, got.caught);
                    fail_count <= fail_count + 1;
                end else begin
                    want = cmd_fifo[rd_count[7:0]];
                    rd_count <= rd_count + 1;
                    if (got !== want || m_tdata[63] !== 1'b0) begin
                        $display("%0t: mismatch expected lin=%h ang=%h caught=%b, %s",
                                 $time, want.lin, want.ang, want.caught, "actual");
                        $display("%0t:   actual lin=%h ang=%h caught=%b pad=%b", $time,
                                 got.lin, got.ang, got.caught, m_tdata[63]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random pose beats into the go-to-goal controller under
// several gain and radius settings and idle patterns, then gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gtg_pkg::*;

    localparam int LATENCY = 6 + 25;
    localparam int IDLE_LIMIT = 20000;

    localparam int idle_sets [4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{21, 21}};
    localparam logic [23:0] gains [4] = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd300000};
    localparam logic [23:0] radii [4] = '{24'd32768, 24'd0, 24'h7FFFFF, 24'd1000};

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [23:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    int           fail_count;
    int           pending;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    go_to_goal_p_controller dut (.*);

    gtg_checker checker_i (.*);

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_pose(logic [1:0] flags, logic [23:0] ox, logic [23:0] oy,
                             logic [18:0] hd, logic [23:0] tx, logic [23:0] ty);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= flags;
        s_tdata <= {5'd0, ty, tx, hd, oy, ox};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    function automatic logic [23:0] rand_pos(bit near);
        if (near) begin
            return 24'($signed($urandom_range(4096)) - 2048);
        end
        return 24'($urandom);
    endfunction

    task automatic random_pose();
        logic [1:0]  flags;
        logic [23:0] ox, oy, tx, ty;
        logic [18:0] hd;
        bit          near;
        flags = ($urandom_range(9) == 0) ? 2'($urandom) : 2'b11;
        near = ($urandom_range(7) == 0);
        ox = rand_pos(near);
        oy = rand_pos(near);
        tx = ($urandom_range(15) == 0) ? ox : rand_pos(near);
        ty = ($urandom_range(15) == 0) ? oy : rand_pos(near);
        hd = ($urandom_range(7) == 0) ? 19'($urandom)
                                      : 19'($signed($urandom_range(411774)) - 205887);
        send_pose(flags, ox, oy, hd, tx, ty);
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_pose(2'b11, 24'h800000, 24'h800000, 19'd0, 24'h7FFFFF, 24'h7FFFFF);
        send_pose(2'b11, 24'h7FFFFF, 24'h7FFFFF, 19'd205887, 24'h800000, 24'h800000);
        send_pose(2'b11, 24'd0, 24'd0, 19'h7FFFF, 24'd0, 24'd0);
        send_pose(2'b11, 24'd0, 24'd0, -19'sd205887, -24'sd65536, 24'd0);
        send_pose(2'b11, 24'd0, 24'd0, 19'd205887, -24'sd65536, -24'sd1);
        send_pose(2'b11, 24'd0, 24'd0, -19'sd205887, -24'sd65536, 24'd1);
        send_pose(2'b11, 24'd0, 24'd0, 19'h3FFFF, 24'd0, 24'd32768);
        send_pose(2'b11, 24'd0, 24'd0, 19'h40000, 24'd0, 24'd32769);
        send_pose(2'b01, 24'd0, 24'd0, 19'd0, 24'd100000, 24'd0);
        send_pose(2'b10, 24'd0, 24'd0, 19'd0, 24'd100000, 24'd0);
        send_pose(2'b00, 24'hFFFFFF, 24'hFFFFFF, 19'h7FFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pose(2'b11, 24'h123456, 24'hFEDCBA, 19'h2AAAA, 24'h800000, 24'h7FFFFF);
        for (int p = 0; p < 4; p++) begin
            drain();
            write_reg(REG_GAIN, gains[p]);
            write_reg(REG_CATCH_RADIUS, radii[p]);
            cfg_wr_en <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                send_idle_pct = idle_sets[k][0];
                recv_stall_pct = idle_sets[k][1];
                repeat (125) random_pose();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/gtg_pkg.sv
src/gtg_front.sv
src/gtg_iter_stage.sv
src/gtg_back.sv
src/go_to_goal_p_controller.sv
dv/gtg_checker.sv
dv/tb_top.sv
